/* hdl/sem_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the RGB Sobel edge magnitude block.
// Used by the front end, the queue, the back end and the top level.
package sem_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int WidthW    = 11;
  localparam int HeightW   = 13;
  localparam int CfgW      = 13;
  localparam int PixW      = 24;
  localparam int SumW      = 21;
  localparam int GradW     = 12;
  localparam logic [SumW-1:0] SatLimit = SumW'(65280);

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  // One queued job: the 3x3 window (row*3+col), the border flags and the frame-end flag.
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic                 top;
    logic                 bot;
    logic                 left;
    logic                 right;
    logic                 last;
  } sem_job_t;

endpackage

/* hdl/sem_front.sv */
`timescale 1ns / 1ps
// Front end: accepts items, keeps the line stores, the window and positions.
// Depends on sem_pkg; pushes finished windows into the job queue.
module sem_front
  import sem_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [7:0]         in_red_i,
  input  logic [7:0]         in_green_i,
  input  logic [7:0]         in_blue_i,
  input  logic               q_full_i,
  output logic               push_o,
  output sem_job_t           job_o
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } fstate_e;

  fstate_e state_q, state_d;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [WidthW-1:0]  eff_w, w_m1, w_p1;
  logic [HeightW-1:0] eff_h, h_m1;

  logic [ColW-1:0]    in_col_q, out_col_q;
  logic [RowW-1:0]    in_row_q, out_row_q;
  logic               pix_done_q;
  logic [WidthW-1:0]  warm_q;
  logic               is_pix_q;
  logic [PixW-1:0]    pix_q;

  logic [2*PixW-1:0]  mem [MaxWidth];
  logic [2*PixW-1:0]  rd_q;
  logic [PixW-1:0]    win_q [3][3];
  logic [PixW-1:0]    col_new [3];

  logic accept, ignore, col_last, in_row_last, emit, out_col_last, out_row_last, frame_end;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = HeightW'(1);
    end else if (height_q > HeightW'(MaxHeight)) begin
      eff_h = HeightW'(MaxHeight);
    end else begin
      eff_h = height_q;
    end
  end

  assign w_m1 = eff_w - WidthW'(1);
  assign w_p1 = eff_w + WidthW'(1);
  assign h_m1 = eff_h - HeightW'(1);

  assign in_stall_o   = (state_q != F_IDLE) || q_full_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign ignore       = (op_i == OpFlush) && !pix_done_q;
  assign col_last     = WidthW'(in_col_q) == w_m1;
  assign in_row_last  = HeightW'(in_row_q) == h_m1;
  assign emit         = (state_q == F_UPD) && (warm_q == w_p1);
  assign out_col_last = WidthW'(out_col_q) == w_m1;
  assign out_row_last = HeightW'(out_row_q) == h_m1;
  assign frame_end    = out_col_last && out_row_last;

  assign col_new[0] = rd_q[2*PixW-1:PixW];
  assign col_new[1] = rd_q[PixW-1:0];
  assign col_new[2] = is_pix_q ? pix_q : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept && !ignore) state_d = F_UPD;
      F_UPD:  state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Job seen by the queue: the window after this item's shift.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job_o.win[i*3]   = win_q[i][1];
      job_o.win[i*3+1] = win_q[i][2];
      job_o.win[i*3+2] = col_new[i];
    end
    job_o.top   = out_row_q == '0;
    job_o.bot   = out_row_last;
    job_o.left  = out_col_q == '0;
    job_o.right = out_col_last;
    job_o.last  = frame_end;
  end
  assign push_o = emit;

  always_ff @(posedge clk_i) begin
    if (accept && !ignore) begin
      rd_q <= mem[in_col_q];
    end
    if (state_q == F_UPD && is_pix_q) begin
      mem[in_col_q] <= {rd_q[PixW-1:0], pix_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !ignore) begin
      is_pix_q <= !pix_done_q;
      pix_q    <= {in_red_i, in_green_i, in_blue_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      width_q    <= WidthW'(640);
      height_q   <= HeightW'(480);
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      pix_done_q <= 1'b0;
      warm_q     <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i || (emit && frame_end)) begin
        if (cfg_we_i) begin
          if (cfg_index_i == CfgWidth) begin
            width_q <= cfg_data_i[WidthW-1:0];
          end else begin
            height_q <= cfg_data_i[HeightW-1:0];
          end
        end
        in_col_q   <= '0;
        in_row_q   <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        pix_done_q <= 1'b0;
        warm_q     <= '0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_q[i][j] <= '0;
          end
        end
      end else if (state_q == F_UPD) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
          win_q[i][2] <= col_new[i];
        end
        if (col_last) begin
          in_col_q <= '0;
          if (is_pix_q) begin
            in_row_q <= in_row_q + RowW'(1);
            if (in_row_last) pix_done_q <= 1'b1;
          end
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
        if (emit) begin
          if (out_col_last) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + RowW'(1);
          end else begin
            out_col_q <= out_col_q + ColW'(1);
          end
        end else begin
          warm_q <= warm_q + WidthW'(1);
        end
      end
    end
  end

endmodule

/* hdl/sem_queue.sv */
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on sem_pkg for the job type.
module sem_queue
  import sem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sem_job_t job_i,
  input  logic     pop_i,
  output sem_job_t job_o,
  output logic     full_o,
  output logic     empty_o
);

  sem_job_t   slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* hdl/sem_back.sv */
`timescale 1ns / 1ps
// Back end: Sobel gradients, squared sum and an 8-step integer root per channel.
// Depends on sem_pkg; pulls jobs from the queue and drives the result register.
module sem_back
  import sem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  sem_job_t job_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic [7:0] edge_red_o,
  output logic [7:0] edge_green_o,
  output logic [7:0] edge_blue_o,
  output logic     frame_end_o
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQ   = 5'b00010,
    B_ROOT = 5'b00100,
    B_FIN  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;

  logic signed [GradW-1:0] gx_q [3], gy_q [3];
  logic signed [GradW-1:0] gx_c [3], gy_c [3];
  logic [SumW-1:0]         s_q [3];
  logic [7:0]              r_q [3];
  logic [7:0]              t_c [3];
  logic [2:0]              bit_q;
  logic                    last_q;
  logic [7:0]              mag_q [3];
  logic [7:0]              v [9];

  // Masked 8-bit samples, then the two kernels, per channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        if ((k < 3 && job_i.top) || (k > 5 && job_i.bot) ||
            ((k % 3) == 0 && job_i.left) || ((k % 3) == 2 && job_i.right)) begin
          v[k] = '0;
        end else begin
          v[k] = job_i.win[k][16-8*ch +: 8];
        end
      end
      gx_c[ch] = GradW'(v[2]) + (GradW'(v[5]) <<< 1) + GradW'(v[8])
               - GradW'(v[0]) - (GradW'(v[3]) <<< 1) - GradW'(v[6]);
      gy_c[ch] = GradW'(v[6]) + (GradW'(v[7]) <<< 1) + GradW'(v[8])
               - GradW'(v[0]) - (GradW'(v[1]) <<< 1) - GradW'(v[2]);
    end
  end

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!empty_i) state_d = B_SQ;
      B_SQ:   state_d = B_ROOT;
      B_ROOT: if (bit_q == '0) state_d = B_FIN;
      B_FIN:  state_d = B_OUT;
      B_OUT:  if (!out_stall_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      t_c[ch] = r_q[ch] | (8'd1 << bit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        for (int ch = 0; ch < 3; ch++) begin
          gx_q[ch] <= gx_c[ch];
          gy_q[ch] <= gy_c[ch];
        end
        last_q <= job_i.last;
      end
      B_SQ: begin
        for (int ch = 0; ch < 3; ch++) begin
          s_q[ch] <= SumW'(gx_q[ch] * gx_q[ch]) + SumW'(gy_q[ch] * gy_q[ch]);
          r_q[ch] <= '0;
        end
        bit_q <= 3'd7;
      end
      B_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (SumW'(t_c[ch] * t_c[ch]) <= s_q[ch]) r_q[ch] <= t_c[ch];
        end
        bit_q <= bit_q - 3'd1;
      end
      B_FIN: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (s_q[ch] > SatLimit) begin
            mag_q[ch] <= 8'd255;
          end else if (s_q[ch] > SumW'(r_q[ch] * r_q[ch]) + SumW'(r_q[ch])) begin
            mag_q[ch] <= r_q[ch] + 8'd1;
          end else begin
            mag_q[ch] <= r_q[ch];
          end
        end
      end
      B_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_valid_o  = state_q == B_OUT;
  assign edge_red_o   = mag_q[0];
  assign edge_green_o = mag_q[1];
  assign edge_blue_o  = mag_q[2];
  assign frame_end_o  = last_q;

endmodule

/* hdl/sobel_edge_magnitude_rgb.sv */
`timescale 1ns / 1ps
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
//
//   Channel  | Handshake             | Payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid_i/in_stall_o | op_i, in_red_i, in_green_i, in_blue_i
//   output   | out_valid_o/out_stall_i | edge_red_o, edge_green_o, edge_blue_o,
//            |                       | frame_end_o
//   config   | cfg_we_i              | cfg_index_i, cfg_data_i
//
// The front end takes an item only when idle and the queue is not full: it
// reads the line store, then writes it and shifts the window before the next
// item. Each result then passes the back end's squared sum, eight-step integer
// square root, rounding and output; the next job waits until the result leaves.
// Reset is asynchronous and active low; the line stores need no clearing pass
// because an entry is only ever used after it has been written.
// A two-entry queue lets the front keep taking items while a result is stalled.
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            op_i,
  input  logic [7:0]      in_red_i,
  input  logic [7:0]      in_green_i,
  input  logic [7:0]      in_blue_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      edge_red_o,
  output logic [7:0]      edge_green_o,
  output logic [7:0]      edge_blue_o,
  output logic            frame_end_o
);

  // Job path: front pushes windows that yield a result, back pops them.
  sem_job_t push_job, head_job;
  logic     push, pop, q_full, q_empty;

  sem_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_red_o   (edge_red_o),
    .edge_green_o (edge_green_o),
    .edge_blue_o  (edge_blue_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

/* tb/tb_sobel_edge_magnitude_rgb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the RGB Sobel edge magnitude block.
// Depends on sem_pkg and sobel_edge_magnitude_rgb; it drives frames of pixel and flush
// items and checks every result item against its own Sobel model.
module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  // One result item as the block reports it.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } edge_pix_t;

  typedef enum logic {RowCfg, RowItem} row_kind_e;

  // One row of the directed table: a register write or an input item, with the
  // expected result typed in where it is obvious.
  typedef struct {
    row_kind_e  kind;
    logic       idx;
    int         data;
    logic       op;
    logic [7:0] red, green, blue;
    bit         typed;
    edge_pix_t  want;
  } stim_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_index_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            op_i = OpPixel;
  logic [7:0]      in_red_i = '0;
  logic [7:0]      in_green_i = '0;
  logic [7:0]      in_blue_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      edge_red_o, edge_green_o, edge_blue_o;
  logic            frame_end_o;

  sobel_edge_magnitude_rgb DUT (.*);

  always #5 clk_i = ~clk_i;

  // Shadow state of the edge detector: registers, line stores, window, positions.
  logic [WidthW-1:0]  shadow_width;
  logic [HeightW-1:0] shadow_height;
  logic [PixW-1:0]    upper_row [MaxWidth];
  logic [PixW-1:0]    lower_row [MaxWidth];
  logic [PixW-1:0]    win [3][3];
  int unsigned        in_pos, out_pos;

  edge_pix_t edge_expect_q[$];
  int        errors = 0;
  int        items_sent = 0, results_seen = 0, frames_done = 0, setups = 0;
  bit        calm = 1'b0;

  task automatic report(string what, int want, int got);
    $display("ERROR %0t: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = '0;
      end
    end
    in_pos = 0;
    out_pos = 0;
  endfunction

  function automatic int unsigned eff_width();
    if (shadow_width == 0) return 1;
    if (shadow_width > MaxWidth) return MaxWidth;
    return shadow_width;
  endfunction

  function automatic int unsigned eff_height();
    if (shadow_height == 0) return 1;
    if (shadow_height > MaxHeight) return MaxHeight;
    return shadow_height;
  endfunction

  // Rounded, saturated root of gx^2 + gy^2, found bit by bit.
  function automatic logic [7:0] round_root(int gx, int gy);
    int unsigned s, r, t;
    s = gx * gx + gy * gy;
    r = 0;
    if (s > 65280) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    if (s > r * r + r) r++;
    return r[7:0];
  endfunction

  // Advances the shadow state by one accepted item; returns 1 with the
  // expected result when the item releases one.
  function automatic bit predict_edges(logic op, logic [PixW-1:0] rgb,
                                       output edge_pix_t res);
    int unsigned w, h, total, p, c, q, orow, ocol;
    logic [PixW-1:0] col [3];
    logic [7:0] mag [3];
    bit is_pix;
    int gx, gy, v;
    w = eff_width();
    h = eff_height();
    total = w * h;
    p = in_pos;
    is_pix = p < total;
    res = '0;
    // A flush that arrives while pixels are still due is dropped outright.
    if (op == OpFlush && is_pix) return 1'b0;
    c = p % w;
    col[0] = upper_row[c];
    col[1] = lower_row[c];
    col[2] = '0;
    if (is_pix) begin
      col[2] = rgb;
      upper_row[c] = col[1];
      lower_row[c] = col[2];
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
      win[k][2] = col[k];
    end
    in_pos = p + 1;
    if (p < w + 1) return 1'b0;
    q = out_pos;
    orow = q / w;
    ocol = q % w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // Neighbors beyond the frame border count as zero.
          if (!((i == 0 && orow == 0) || (i == 2 && orow + 1 >= h) ||
                (j == 0 && ocol == 0) || (j == 2 && ocol + 1 >= w))) begin
            v = (win[i][j] >> (16 - 8 * ch)) & 8'hFF;
            gx += v * (j - 1) * (i == 1 ? 2 : 1);
            gy += v * (i - 1) * (j == 1 ? 2 : 1);
          end
        end
      end
      mag[ch] = round_root(gx, gy);
    end
    res.red = mag[0];
    res.green = mag[1];
    res.blue = mag[2];
    out_pos = q + 1;
    if (q + 1 >= total) begin
      res.fend = 1'b1;
      restart_frame();
    end
    return 1'b1;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one item, holds it until accepted, then predicts and optionally idles.
  task automatic send(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                      bit typed = 1'b0, edge_pix_t want = '0);
    edge_pix_t res;
    int gap;
    in_valid_i <= 1'b1;
    op_i <= op;
    in_red_i <= r;
    in_green_i <= g;
    in_blue_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (predict_edges(op, {r, g, b}, res)) begin
      if (res.fend) frames_done++;
      edge_expect_q.push_back(typed ? want : res);
    end
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lets the block drain: every result in, then room for items that release
  // none but may still be in the front end.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (edge_expect_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  // One register write; the enable drops for a cycle before the next one.
  task automatic write_reg(logic idx, int data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgWidth) shadow_width = data[WidthW-1:0];
    else shadow_height = data[HeightW-1:0];
    restart_frame();
    @(posedge clk_i);
  endtask

  // One frame: pixels with stray early flushes, then the flush tail, part of
  // which may be late pixels. A cut frame stops partway.
  task automatic run_frame(bit cut, ref int counted);
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    n = cut ? $urandom_range(0, w * h - 1) : w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        send(OpFlush, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      send(OpPixel, 8'($urandom), 8'($urandom), 8'($urandom));
      counted++;
    end
    if (cut) return;
    for (int unsigned i = 0; i <= w; i++) begin
      send($urandom_range(0, 99) < 20 ? OpPixel : OpFlush,
           8'($urandom), 8'($urandom), 8'($urandom));
      counted++;
    end
  endtask

  function automatic stim_row_t cfg_row(logic idx, int data);
    stim_row_t row;
    row = '{kind: RowCfg, idx: idx, data: data, op: OpPixel, red: 0, green: 0,
            blue: 0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t item_row(logic op, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, bit typed = 1'b0,
                                         edge_pix_t want = '0);
    stim_row_t row;
    row = '{kind: RowItem, idx: CfgWidth, data: 0, op: op, red: r, green: g,
            blue: b, typed: typed, want: want};
    return row;
  endfunction

  // Receiver stall: mostly open, short holds, sometimes long ones.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          out_stall_i <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
        4: begin
          out_stall_i <= 1'b1;
          stall_left <= $urandom_range(10, 40);
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Stretches without any idling on either side come and go.
  always begin
    repeat ($urandom_range(300, 900)) @(posedge clk_i);
    calm = ($urandom_range(0, 3) == 0);
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    edge_pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (edge_expect_q.size() == 0) begin
        report("unexpected result, queued results", 0, 1);
      end else begin
        want = edge_expect_q.pop_front();
        if (edge_red_o !== want.red) report("edge_red", want.red, edge_red_o);
        if (edge_green_o !== want.green) report("edge_green", want.green, edge_green_o);
        if (edge_blue_o !== want.blue) report("edge_blue", want.blue, edge_blue_o);
        if (frame_end_o !== want.fend) report("frame_end", want.fend, frame_end_o);
      end
    end
  end

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", edge_expect_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t table_rows[$];
    int counted;
    int unsigned w, h;
    edge_pix_t zero_end;
    zero_end = '{red: 0, green: 0, blue: 0, fend: 1'b1};

    // A 1x1 frame has no neighbor in any direction, so its result is zero.
    table_rows.push_back(cfg_row(CfgWidth, 1));
    table_rows.push_back(cfg_row(CfgHeight, 1));
    table_rows.push_back(item_row(OpFlush, 8'h12, 8'h34, 8'h56));
    table_rows.push_back(item_row(OpPixel, 8'hFF, 8'h00, 8'h80));
    table_rows.push_back(item_row(OpFlush, 8'h00, 8'h00, 8'h00));
    table_rows.push_back(item_row(OpFlush, 8'h00, 8'h00, 8'h00, 1'b1, zero_end));
    // Late pixels stand in for the flush tail.
    table_rows.push_back(item_row(OpPixel, 8'hFF, 8'hFF, 8'hFF));
    table_rows.push_back(item_row(OpPixel, 8'hAA, 8'h55, 8'hFF));
    table_rows.push_back(item_row(OpPixel, 8'h55, 8'hAA, 8'h00, 1'b1, zero_end));
    // Zero in both registers acts as a 1x1 frame.
    table_rows.push_back(cfg_row(CfgWidth, 0));
    table_rows.push_back(cfg_row(CfgHeight, 0));
    table_rows.push_back(item_row(OpPixel, 8'h01, 8'h02, 8'h03));
    table_rows.push_back(item_row(OpFlush, 8'h00, 8'h00, 8'h00));
    table_rows.push_back(item_row(OpFlush, 8'h00, 8'h00, 8'h00, 1'b1, zero_end));
    // A 3x3 checkerboard of full and empty pixels drives the root into saturation.
    table_rows.push_back(cfg_row(CfgWidth, 3));
    table_rows.push_back(cfg_row(CfgHeight, 3));
    for (int i = 0; i < 9; i++) begin
      table_rows.push_back(i % 2 ? item_row(OpPixel, 8'h00, 8'hFF, 8'h00)
                                 : item_row(OpPixel, 8'hFF, 8'h00, 8'hFF));
    end
    for (int i = 0; i < 4; i++) table_rows.push_back(item_row(OpFlush, 8'h00, 8'h00, 8'h00));

    shadow_width = 640;
    shadow_height = 480;
    for (int i = 0; i < MaxWidth; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    restart_frame();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == RowCfg) begin
        wait_idle();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        send(table_rows[i].op, table_rows[i].red, table_rows[i].green,
             table_rows[i].blue, table_rows[i].typed, table_rows[i].want);
      end
    end

    // Extremes: all width bits set clamps to the widest row; one full line and
    // the start of its flush tail. Then a single column with all height bits
    // set, cut short. The next register write restarts each frame.
    counted = 0;
    wait_idle();
    write_reg(CfgWidth, 2047);
    write_reg(CfgHeight, 1);
    for (int i = 0; i < MaxWidth; i++) begin
      send(OpPixel, 8'($urandom), 8'($urandom), 8'($urandom));
      counted++;
    end
    for (int i = 0; i < 24; i++) begin
      send(OpFlush, 8'h00, 8'h00, 8'h00);
      counted++;
    end
    wait_idle();
    write_reg(CfgHeight, 8191);
    write_reg(CfgWidth, 1);
    for (int i = 0; i < 60; i++) begin
      send(OpPixel, 8'($urandom), 8'($urandom), 8'($urandom));
      counted++;
    end
    setups = 2;

    // Random setups, mostly small frames, a few wide ones.
    while (counted < 1450) begin
      wait_idle();
      case ($urandom_range(0, 19))
        0: w = 0;
        1, 2, 3: w = $urandom_range(41, 200);
        4, 5, 6, 7, 8: w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      h = (w > 40) ? $urandom_range(1, 3) : $urandom_range(0, 8);
      if ($urandom_range(0, 1)) begin
        write_reg(CfgWidth, w);
        write_reg(CfgHeight, h);
      end else begin
        write_reg(CfgHeight, h);
        write_reg(CfgWidth, w);
      end
      setups++;
      for (int f = $urandom_range(1, 3); f > 0 && counted < 1450; f--) begin
        run_frame(f == 1 && $urandom_range(0, 99) < 8, counted);
      end
    end

    wait_idle();
    $display("Ran %0d items over %0d frame setups; %0d results checked, %0d frames closed.",
             items_sent, setups, results_seen, frames_done);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/sem_pkg.sv
hdl/sem_front.sv
hdl/sem_queue.sv
hdl/sem_back.sv
hdl/sobel_edge_magnitude_rgb.sv
tb/tb_sobel_edge_magnitude_rgb.sv
